/* sv/qppc_pkg.sv */
// ============================================================================
// Quadrature position PI controller: shared definitions
// Types, codes, constants and the duty-to-PWM scaling table used by the
// counter, the PI datapath and the top level.
// ============================================================================
package qppc_pkg;

    // Build-time constants of the controller.
    localparam int PWM_MAX        = 255;
    localparam int COUNT_BITS     = 16;
    localparam bit ENCODER_INVERT = 1'b0;
    localparam bit DRIVE_INVERT   = 1'b0;

    // Magnitude bits of a PWM level and bits of the signed motor command.
    localparam int PWM_W   = $clog2(PWM_MAX + 1);
    localparam int CMD_W   = PWM_W + 1;
    // Floor comparison width: the floors are 8-bit registers.
    localparam int FLOOR_W = (PWM_W > 8) ? PWM_W : 8;
    // Position error width: target is 16 bits, the count COUNT_BITS.
    localparam int ERR_W   = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    // Reported position clamp width.
    localparam int POS_W   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    // Products and the accumulator of the PI sum.
    localparam int PTERM_W = 25 + ERR_W;
    localparam int ITERM_W = 57;
    localparam int ACC_W   = ((PTERM_W > ITERM_W) ? PTERM_W : ITERM_W) + 1;
    // Integral update width: 32-bit integral plus an error clamped to 32 bits.
    localparam int SUM_W   = 34;

    // Scaled duty below this many whole percent is looked up; at or above, full drive.
    localparam int PCT_FULL = 100;

    // Item kinds carried in tuser.
    typedef enum logic [1:0] {
        MODE_HALL = 2'd0,
        MODE_TICK = 2'd1,
        MODE_ZERO = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PROP_GAIN       = 3'd0,
        REG_INTEG_GAIN      = 3'd1,
        REG_POSITION_MIN    = 3'd2,
        REG_POSITION_MAX    = 3'd3,
        REG_TOLERANCE       = 3'd4,
        REG_MIN_EXTEND_PWM  = 3'd5,
        REG_MIN_RETRACT_PWM = 3'd6,
        REG_DUTY_LIMIT      = 3'd7
    } reg_index_t;

    // Result of decoding one hall sample against the previous one.
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    typedef struct packed {
        logic        [23:0] prop_gain;
        logic        [23:0] integ_gain;
        logic signed [15:0] position_min;
        logic signed [15:0] position_max;
        logic        [15:0] tolerance;
        logic        [7:0]  min_extend_pwm;
        logic        [7:0]  min_retract_pwm;
        logic        [6:0]  duty_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0]      integral_sum;
        logic signed [31:0]      duty_value;
        logic signed [CMD_W-1:0] motor_command;
        logic                    tolerance_flag;
    } loop_state_t;

    // Quadrature decode of {previous A, previous B, A, B}. Double steps and
    // unchanged levels give no step.
    function automatic step_t hall_step(input logic [3:0] code);
        step_t s;
        unique case (code)
            4'b0010, 4'b1011, 4'b1101, 4'b0100: s = STEP_UP;
            4'b0001, 4'b0111, 4'b1110, 4'b1000: s = STEP_DOWN;
            default:                            s = STEP_NONE;
        endcase
        return s;
    endfunction

    // Whole percent of duty to PWM level, truncating.
    typedef logic [PWM_W-1:0] pwm_lut_t [0:PCT_FULL-1];

    function automatic pwm_lut_t build_pwm_lut();
        pwm_lut_t lut;
        for (int i = 0; i < PCT_FULL; i++) begin
            lut[i] = PWM_W'((i * PWM_MAX) / PCT_FULL);
        end
        return lut;
    endfunction

    localparam pwm_lut_t PWM_LUT = build_pwm_lut();

endpackage

/* sv/qppc_quad_counter.sv */
// ============================================================================
// Quadrature position counter
// Decodes one hall sample against the previous levels and updates the
// saturating position count and the wrapping transition count.
// ============================================================================
module qppc_quad_counter (
    input  logic [1:0]                           last_hall,
    input  logic [1:0]                           hall,
    input  logic signed [qppc_pkg::COUNT_BITS-1:0] position,
    input  logic [15:0]                          transitions,
    output logic signed [qppc_pkg::COUNT_BITS-1:0] position_next,
    output logic [15:0]                          transitions_next
);
    import qppc_pkg::*;

    localparam logic signed [COUNT_BITS-1:0] POS_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] POS_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    step_t step;
    logic  go_up;
    logic  go_down;

    always_comb begin
        step    = hall_step({last_hall, hall});
        // An inverted encoder swaps the sense of the two directions.
        go_up   = ENCODER_INVERT ? (step == STEP_DOWN) : (step == STEP_UP);
        go_down = ENCODER_INVERT ? (step == STEP_UP) : (step == STEP_DOWN);

        position_next    = position;
        transitions_next = transitions;
        if (go_up || go_down) begin
            transitions_next = transitions + 16'd1;
        end
        if (go_up && (position != POS_MAX)) begin
            position_next = position + COUNT_BITS'(1);
        end else if (go_down && (position != POS_MIN)) begin
            position_next = position - COUNT_BITS'(1);
        end
    end

endmodule

/* sv/qppc_pwm_map.sv */
// ============================================================================
// Duty to PWM mapping
// Scales whole percent of duty to a PWM level, applies the extend and
// retract floors, clamps to full drive and signs the result.
// ============================================================================
module qppc_pwm_map (
    input  logic signed [31:0]                 duty,
    input  logic [7:0]                         min_extend_pwm,
    input  logic [7:0]                         min_retract_pwm,
    output logic signed [qppc_pkg::CMD_W-1:0]  command
);
    import qppc_pkg::*;

    localparam logic [FLOOR_W-1:0] FULL = FLOOR_W'(PWM_MAX);

    logic [31:0]        mag;
    logic [23:0]        whole_pct;
    logic [PWM_W-1:0]   scaled;
    logic [FLOOR_W-1:0] floored;
    logic [FLOOR_W-1:0] floor_val;
    logic [PWM_W-1:0]   level;

    always_comb begin
        mag       = duty[31] ? (~duty + 32'd1) : duty;
        whole_pct = mag[31:8];
        // At or above full percent the scaled level already reaches full drive.
        if (whole_pct >= 24'(PCT_FULL)) begin
            scaled = PWM_W'(PWM_MAX);
        end else begin
            scaled = PWM_LUT[whole_pct[6:0]];
        end
        floor_val = duty[31] ? FLOOR_W'(min_retract_pwm) : FLOOR_W'(min_extend_pwm);
        floored   = (FLOOR_W'(scaled) < floor_val) ? floor_val : FLOOR_W'(scaled);
        level     = (floored > FULL) ? PWM_W'(PWM_MAX) : PWM_W'(floored);

        if (duty == 32'sd0) begin
            command = '0;
        end else if (duty[31]) begin
            command = -$signed({1'b0, level});
        end else begin
            command = $signed({1'b0, level});
        end
    end

endmodule

/* sv/qppc_pi_loop.sv */
// ============================================================================
// Position PI datapath
// Computes one control tick: target clamp, error, rounded and saturated
// duty, anti-windup integral update, deadband and PWM command.
// ============================================================================
module qppc_pi_loop (
    input  qppc_pkg::cfg_t                          cfg,
    input  logic signed [qppc_pkg::COUNT_BITS-1:0]  position,
    input  logic signed [15:0]                      target_position,
    input  logic                                    enable,
    input  qppc_pkg::loop_state_t                   state,
    output qppc_pkg::loop_state_t                   state_next
);
    import qppc_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_POS  = ACC_W'(128);
    localparam logic signed [ACC_W-1:0] RND_NEG  = ACC_W'(127);
    localparam logic signed [ACC_W-1:0] DUTY_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] DUTY_MIN = {{(ACC_W-31){1'b1}}, 31'd0};
    localparam logic signed [SUM_W-1:0] S32_MAX  = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] S32_MIN  = {{(SUM_W-31){1'b1}}, 31'd0};

    logic signed [15:0]        target;
    logic signed [ERR_W-1:0]   err;
    logic        [ERR_W-1:0]   err_mag;
    logic signed [PTERM_W-1:0] p_term;
    logic signed [ITERM_W-1:0] i_term;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   rounded;
    logic signed [ACC_W-1:0]   duty_wide;
    logic signed [31:0]        duty;
    logic signed [16:0]        lim;
    logic                      in_band;
    logic signed [SUM_W-1:0]   err_sat;
    logic signed [SUM_W-1:0]   sum;
    logic signed [31:0]        integral_upd;
    logic                      in_dead;
    logic signed [CMD_W-1:0]   command;

    qppc_pwm_map u_pwm_map (
        .duty            (duty),
        .min_extend_pwm  (cfg.min_extend_pwm),
        .min_retract_pwm (cfg.min_retract_pwm),
        .command         (command)
    );

    always_comb begin
        // A target below the minimum wins over the maximum when they cross.
        if (target_position < cfg.position_min) begin
            target = cfg.position_min;
        end else if (target_position > cfg.position_max) begin
            target = cfg.position_max;
        end else begin
            target = target_position;
        end
        err     = ERR_W'(target) - ERR_W'(position);
        err_mag = err[ERR_W-1] ? (~err + ERR_W'(1)) : err;

        p_term  = $signed({1'b0, cfg.prop_gain}) * err;
        i_term  = $signed({1'b0, cfg.integ_gain}) * state.integral_sum;
        acc     = ACC_W'(p_term) + ACC_W'(i_term);

        // Divide by 256 rounding half away from zero.
        rounded   = (acc + (acc[ACC_W-1] ? RND_NEG : RND_POS)) >>> 8;
        duty_wide = (rounded > DUTY_MAX) ? DUTY_MAX :
                    ((rounded < DUTY_MIN) ? DUTY_MIN : rounded);
        duty      = duty_wide[31:0];

        // Anti-windup: integrate only while the duty sits inside the limit.
        lim     = $signed({2'b00, cfg.duty_limit, 8'h00});
        in_band = (duty >= 32'(-lim)) && (duty <= 32'(lim));
        err_sat = (SUM_W'(err) > S32_MAX) ? S32_MAX :
                  ((SUM_W'(err) < S32_MIN) ? S32_MIN : SUM_W'(err));
        sum     = SUM_W'(state.integral_sum) + err_sat;
        integral_upd = (sum > S32_MAX) ? 32'sh7FFF_FFFF :
                       ((sum < S32_MIN) ? 32'sh8000_0000 : sum[31:0]);

        in_dead = err_mag < ERR_W'(cfg.tolerance);

        state_next = state;
        if (!enable) begin
            state_next.integral_sum   = '0;
            state_next.duty_value     = '0;
            state_next.motor_command  = '0;
            state_next.tolerance_flag = 1'b0;
        end else if (in_dead) begin
            state_next.integral_sum   = '0;
            state_next.duty_value     = '0;
            state_next.motor_command  = '0;
            state_next.tolerance_flag = 1'b1;
        end else begin
            state_next.integral_sum   = in_band ? integral_upd : state.integral_sum;
            state_next.duty_value     = duty;
            state_next.motor_command  = command;
            state_next.tolerance_flag = 1'b0;
        end
    end

endmodule

/* sv/quadrature_position_pi_controller_unit.sv */
// ============================================================================
// Quadrature position PI controller, top level
// Input register, controller state, configuration registers and result
// register around the quadrature counter and the PI datapath.
// ============================================================================
//
//  Channel   Direction  Handshake             Payload
//  s_        in         s_tvalid / s_tready   s_tuser: mode; s_tdata: hall and target
//  m_        out        m_tvalid / m_tready   m_tdata: drive levels and status
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An accepted item waits in the input register until the result register is free
// or emptying; it is processed at the edge that updates the controller state and
// loads the result register, and the result is offered from that edge on. One item
// per cycle is sustained while the result is not stalled, a rate set by the position
// and integral feedback closing through the PI datapath. A stalled result holds in
// the result register while one more item waits in the input register; only then
// is s_tready dropped. Reset (aresetn low, synchronous) empties both registers,
// clears the state and loads the register defaults. cfg_ready is always high.
//
module quadrature_position_pi_controller_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hall_a [0], hall_b [1], target_position [17:2],
                                   // enable [18], zero [23:19]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // drive_in1 [7:0], drive_in2 [15:8],
                                   // pwm_command [24:16], position [40:25],
                                   // transitions [56:41], duty_percent [72:57],
                                   // in_tolerance [73], zero [79:74]
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import qppc_pkg::*;

    localparam logic signed [POS_W-1:0] POS16_MAX = POS_W'(16'sh7FFF);
    localparam logic signed [POS_W-1:0] POS16_MIN = POS_W'(16'sh8000);

    // Input register.
    logic                      in_valid_reg;
    logic [1:0]                in_mode_reg;
    logic [1:0]                in_hall_reg;
    logic signed [15:0]        in_target_reg;
    logic                      in_enable_reg;

    // Configuration and controller state.
    cfg_t                      cfg_reg;
    logic [1:0]                last_hall_reg;
    logic [1:0]                last_hall_next;
    logic signed [COUNT_BITS-1:0] position_reg;
    logic signed [COUNT_BITS-1:0] position_next;
    logic [15:0]               transitions_reg;
    logic [15:0]               transitions_next;
    loop_state_t               loop_reg;
    loop_state_t               loop_next;

    // Result register.
    logic                      m_tvalid_reg;
    logic [79:0]               m_tdata_reg;
    logic [79:0]               m_tdata_next;

    logic                      advance;
    logic signed [COUNT_BITS-1:0] count_pos;
    logic [15:0]               count_trans;
    loop_state_t               tick_state;
    logic signed [CMD_W-1:0]   drive_raw;
    logic signed [POS_W-1:0]   pos_wide;
    logic [15:0]               pos_out;
    logic [15:0]               duty_out;
    logic [7:0]                drive_in1;
    logic [7:0]                drive_in2;

    // The held item moves on whenever the result register is free or emptying.
    assign advance   = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    qppc_quad_counter u_quad_counter (
        .last_hall        (last_hall_reg),
        .hall             (in_hall_reg),
        .position         (position_reg),
        .transitions      (transitions_reg),
        .position_next    (count_pos),
        .transitions_next (count_trans)
    );

    qppc_pi_loop u_pi_loop (
        .cfg             (cfg_reg),
        .position        (position_reg),
        .target_position (in_target_reg),
        .enable          (in_enable_reg),
        .state           (loop_reg),
        .state_next      (tick_state)
    );

    // Next controller state for the held item.
    always_comb begin
        last_hall_next   = last_hall_reg;
        position_next    = position_reg;
        transitions_next = transitions_reg;
        loop_next        = loop_reg;
        if (advance) begin
            unique case (in_mode_reg)
                MODE_HALL: begin
                    position_next    = count_pos;
                    transitions_next = count_trans;
                    last_hall_next   = in_hall_reg;
                end
                MODE_TICK: begin
                    loop_next = tick_state;
                end
                MODE_ZERO: begin
                    // The motor command and the deadband flag are kept.
                    position_next           = '0;
                    transitions_next        = '0;
                    last_hall_next          = in_hall_reg;
                    loop_next.integral_sum  = '0;
                    loop_next.duty_value    = '0;
                end
                default: begin
                    // The unused mode only reports the state.
                end
            endcase
        end
    end

    // Result fields, taken from the state after the item.
    always_comb begin
        drive_raw = DRIVE_INVERT ? -loop_next.motor_command : loop_next.motor_command;
        drive_in1 = (drive_raw > 0) ? 8'(drive_raw) : 8'd0;
        drive_in2 = (drive_raw < 0) ? 8'(-drive_raw) : 8'd0;

        pos_wide = POS_W'(position_next);
        if (pos_wide > POS16_MAX) begin
            pos_out = 16'h7FFF;
        end else if (pos_wide < POS16_MIN) begin
            pos_out = 16'h8000;
        end else begin
            pos_out = pos_wide[15:0];
        end

        if (loop_next.duty_value > 32'sd32767) begin
            duty_out = 16'h7FFF;
        end else if (loop_next.duty_value < -32'sd32768) begin
            duty_out = 16'h8000;
        end else begin
            duty_out = loop_next.duty_value[15:0];
        end

        m_tdata_next = {6'd0,
                        loop_next.tolerance_flag,
                        duty_out,
                        transitions_next,
                        pos_out,
                        9'(loop_next.motor_command),
                        drive_in2,
                        drive_in1};
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg   <= s_tuser;
            in_hall_reg   <= {s_tdata[0], s_tdata[1]};
            in_target_reg <= $signed(s_tdata[17:2]);
            in_enable_reg <= s_tdata[18];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain       <= 24'd65536;
            cfg_reg.integ_gain      <= '0;
            cfg_reg.position_min    <= '0;
            cfg_reg.position_max    <= 16'sh7FFF;
            cfg_reg.tolerance       <= 16'd1;
            cfg_reg.min_extend_pwm  <= '0;
            cfg_reg.min_retract_pwm <= '0;
            cfg_reg.duty_limit      <= 7'd100;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PROP_GAIN:       cfg_reg.prop_gain       <= cfg_data;
                REG_INTEG_GAIN:      cfg_reg.integ_gain      <= cfg_data;
                REG_POSITION_MIN:    cfg_reg.position_min    <= $signed(cfg_data[15:0]);
                REG_POSITION_MAX:    cfg_reg.position_max    <= $signed(cfg_data[15:0]);
                REG_TOLERANCE:       cfg_reg.tolerance       <= cfg_data[15:0];
                REG_MIN_EXTEND_PWM:  cfg_reg.min_extend_pwm  <= cfg_data[7:0];
                REG_MIN_RETRACT_PWM: cfg_reg.min_retract_pwm <= cfg_data[7:0];
                REG_DUTY_LIMIT:      cfg_reg.duty_limit      <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_hall_reg   <= '0;
            position_reg    <= '0;
            transitions_reg <= '0;
            loop_reg        <= '0;
        end else begin
            last_hall_reg   <= last_hall_next;
            position_reg    <= position_next;
            transitions_reg <= transitions_next;
            loop_reg        <= loop_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

/* sv/qppc_checker.sv */
// ============================================================================
// Quadrature position PI controller, port checker
// Watches the result channel of the top level over time.
// ============================================================================
module qppc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // Reset empties both item registers.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("result pending or input blocked after reset");

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // The bridge is never driven both ways.
    a_bridge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:0] == 8'd0) || (m_tdata[15:8] == 8'd0)))
        else $error("both bridge inputs driven");

    // Inside the deadband the motor command is zero.
    a_deadband: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[73]) |-> (m_tdata[24:16] == 9'd0))
        else $error("motor driven inside deadband");

endmodule

bind quadrature_position_pi_controller_unit qppc_checker u_qppc_checker (.*);
